// File: hw/rtl/wrench_ema_filter_with_tare_top_defines.svh
// Assertion macros shared by the filter RTL.
// Both expect clk and arst_n in scope.
`ifndef WRENCH_EMA_FILTER_WITH_TARE_TOP_DEFINES_SVH
`define WRENCH_EMA_FILTER_WITH_TARE_TOP_DEFINES_SVH

// same-cycle implication
`define WEMAFT_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define WEMAFT_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: hw/rtl/wemaft_pkg.sv
package wemaft_pkg;

	localparam int CHANNELS     = 6;
	localparam int TARE_SAMPLES = 50;
	localparam int SAMPLE_W     = 32;

	localparam int GAIN_W    = 17;
	localparam int GAIN_FRAC = 16;
	localparam logic [GAIN_W-1:0] GAIN_ONE   = GAIN_W'(1 << GAIN_FRAC);
	localparam logic [GAIN_W-1:0] GAIN_RESET = GAIN_W'(6554);
	localparam int BLEND_W   = GAIN_W + SAMPLE_W + 2;
	localparam int BLEND_RND = 1 << (GAIN_FRAC - 1);

	localparam int CNT_W = $clog2(TARE_SAMPLES + 1);
	localparam int SUM_W = SAMPLE_W + CNT_W;

	// average: |sum| + half, times a reciprocal, exact for the whole range
	localparam int TARE_HALF = TARE_SAMPLES / 2;
	localparam int NUM_W     = SUM_W - 1;
	localparam int DIV_L     = $clog2(TARE_SAMPLES);
	localparam int DIV_S     = NUM_W + DIV_L;
	localparam int DIV_MW    = NUM_W + 1;
	localparam logic [DIV_MW-1:0] DIV_M =
		DIV_MW'(((64'd1 << DIV_S) + 64'(TARE_SAMPLES - 1)) / 64'(TARE_SAMPLES));
	localparam int A_LO_W = NUM_W / 2;
	localparam int A_HI_W = NUM_W - A_LO_W;
	localparam int B_LO_W = DIV_MW / 2;
	localparam int B_HI_W = DIV_MW - B_LO_W;
	localparam int PROD_W = NUM_W + DIV_MW;

	localparam logic KIND_SAMPLE = 1'b0;
	localparam logic KIND_TARE   = 1'b1;

	typedef logic [SAMPLE_W-1:0] word_t;
	typedef word_t [CHANNELS-1:0] wrench_t;

	typedef struct packed {
		wrench_t val;
		logic    busy;
	} rslt_t;

endpackage

// File: hw/rtl/wemaft_avg_div.sv
module wemaft_avg_div
	import wemaft_pkg::*;
(
	input  logic                       clk,
	input  logic                       en,
	input  logic signed [SUM_W-1:0]    sum,
	output logic signed [SAMPLE_W-1:0] avg
);

	logic [SUM_W-1:0]         num;
	logic                     neg_s4, neg_s5, neg_s6;
	logic [NUM_W-1:0]         num_s4;
	logic [A_LO_W+B_LO_W-1:0] pp_ll_s5;
	logic [A_LO_W+B_HI_W-1:0] pp_lh_s5;
	logic [A_HI_W+B_LO_W-1:0] pp_hl_s5;
	logic [A_HI_W+B_HI_W-1:0] pp_hh_s5;
	logic [PROD_W-1:0]        prod;
	logic [SAMPLE_W-1:0]      q_s6;

	// round half away from zero on the magnitude
	assign num = sum[SUM_W-1] ? (SUM_W'(TARE_HALF) - $unsigned(sum))
	                          : ($unsigned(sum) + SUM_W'(TARE_HALF));

	assign prod = (PROD_W'(pp_hh_s5) << (A_LO_W + B_LO_W))
	            + (PROD_W'(pp_hl_s5) << A_LO_W)
	            + (PROD_W'(pp_lh_s5) << B_LO_W)
	            + PROD_W'(pp_ll_s5);

	always_ff @(posedge clk) begin
		if (en) begin
			neg_s4   <= sum[SUM_W-1];
			num_s4   <= num[NUM_W-1:0];
			neg_s5   <= neg_s4;
			pp_ll_s5 <= (A_LO_W+B_LO_W)'(num_s4[A_LO_W-1:0])
			          * (A_LO_W+B_LO_W)'(DIV_M[B_LO_W-1:0]);
			pp_lh_s5 <= (A_LO_W+B_HI_W)'(num_s4[A_LO_W-1:0])
			          * (A_LO_W+B_HI_W)'(DIV_M[DIV_MW-1:B_LO_W]);
			pp_hl_s5 <= (A_HI_W+B_LO_W)'(num_s4[NUM_W-1:A_LO_W])
			          * (A_HI_W+B_LO_W)'(DIV_M[B_LO_W-1:0]);
			pp_hh_s5 <= (A_HI_W+B_HI_W)'(num_s4[NUM_W-1:A_LO_W])
			          * (A_HI_W+B_HI_W)'(DIV_M[DIV_MW-1:B_LO_W]);
			neg_s6   <= neg_s5;
			q_s6     <= prod[DIV_S +: SAMPLE_W];
		end
	end

	assign avg = neg_s6 ? $signed(-q_s6) : $signed(q_s6);

endmodule

// File: hw/rtl/wemaft_out_buf.sv
module wemaft_out_buf
	import wemaft_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  up_valid,
	output logic  up_ready,
	input  rslt_t up_data,
	output logic  dn_valid,
	input  logic  dn_ready,
	output rslt_t dn_data
);

	logic  out_valid_q, skid_valid_q;
	rslt_t out_q, skid_q;

	assign up_ready = !skid_valid_q;
	assign dn_valid = out_valid_q;
	assign dn_data  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (out_valid_q && dn_ready) begin
			if (skid_valid_q) begin
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= up_valid;
			end
		end else if (!out_valid_q) begin
			out_valid_q <= up_valid;
		end else if (up_valid && !skid_valid_q) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_valid_q && dn_ready) begin
			out_q <= skid_valid_q ? skid_q : up_data;
		end else if (!out_valid_q) begin
			out_q <= up_data;
		end else if (!skid_valid_q) begin
			skid_q <= up_data;
		end
	end

endmodule

// File: hw/rtl/wrench_ema_filter_with_tare_top.sv
// Six-axis force/torque conditioner: EMA filter with tare offset removal.
// Input channel in_valid/in_ready carries kind plus six Q15.16 raw values.
// A sample (kind 0) yields one result on out_valid/out_ready: the filtered
// values minus the tare offsets, saturated, and tare_busy. A tare request
// (kind 1) yields no result; unless a tare is running, it averages the next
// 50 filtered values, which then become the offsets, and the filter reseeds
// on the next sample. smoothing_gain is written on cfg_valid/cfg_ready
// (always ready); the user must write it only while the block is idle, and
// the block does not enforce this; values above 65536 act as 65536. Each
// result is held in the output register. Throughput: one request per cycle
// while in_ready is high; the filter update is one multiply-add per channel.
// The output register has a skid stage behind it, so one more result is
// absorbed when the receiver stalls; after that in_ready drops and the whole
// pipeline holds until out_ready returns.
// Reset: gain 6554, offsets zero, filter unseeded, no tare running.
`include "wrench_ema_filter_with_tare_top_defines.svh"

module wrench_ema_filter_with_tare_top
	import wemaft_pkg::*;
(
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [GAIN_W-1:0]          smoothing_gain,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic                       kind,
	input  logic signed [SAMPLE_W-1:0] force_x,
	input  logic signed [SAMPLE_W-1:0] force_y,
	input  logic signed [SAMPLE_W-1:0] force_z,
	input  logic signed [SAMPLE_W-1:0] torque_x,
	input  logic signed [SAMPLE_W-1:0] torque_y,
	input  logic signed [SAMPLE_W-1:0] torque_z,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic signed [SAMPLE_W-1:0] out_force_x,
	output logic signed [SAMPLE_W-1:0] out_force_y,
	output logic signed [SAMPLE_W-1:0] out_force_z,
	output logic signed [SAMPLE_W-1:0] out_torque_x,
	output logic signed [SAMPLE_W-1:0] out_torque_y,
	output logic signed [SAMPLE_W-1:0] out_torque_z,
	output logic                       tare_busy
);

	logic              adv;
	logic [GAIN_W-1:0] gain_q, g_eff;

	logic              v_s1, kind_s1;
	wrench_t           x_s1, in_x;

	wrench_t           f_q, f_upd;
	logic              seeded_q, running_q;
	logic [CNT_W-1:0]  cnt_q, cnt_inc;
	logic              is_tare, done;

	logic signed [SAMPLE_W:0]  diff [CHANNELS];
	logic signed [BLEND_W-1:0] prod [CHANNELS];
	logic signed [BLEND_W-1:0] rnd  [CHANNELS];

	logic              v_s2, clr_s2, acc_s2, done_s2, busy_s2;
	logic              v_s3, v_s4, v_s5, v_s6;
	logic              busy_s3, busy_s4, busy_s5, busy_s6;
	logic              dv_s3, dv_s4, dv_s5, dv_s6;
	wrench_t           f_s2, f_s3, f_s4, f_s5, f_s6;

	logic signed [SUM_W-1:0]    sum_q   [CHANNELS];
	logic signed [SUM_W-1:0]    fin_s3  [CHANNELS];
	logic signed [SUM_W-1:0]    f_ext   [CHANNELS];
	logic signed [SAMPLE_W-1:0] avg     [CHANNELS];
	wrench_t                    off_q;

	logic signed [SAMPLE_W:0]   tared [CHANNELS];
	rslt_t                      rslt, out_data;

	assign cfg_ready = 1'b1;
	assign in_x = {torque_z, torque_y, torque_x, force_z, force_y, force_x};
	assign in_ready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q <= GAIN_RESET;
		end else if (cfg_valid) begin
			gain_q <= smoothing_gain;
		end
	end

	// stage 1: input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			kind_s1 <= kind;
			x_s1    <= in_x;
		end
	end

	// filter update: f + round(g*(x - f) / 2^16), or x while unseeded
	assign g_eff = gain_q[GAIN_W-1] ? GAIN_ONE : gain_q;

	always_comb begin
		for (int c = 0; c < CHANNELS; c++) begin
			diff[c] = $signed({x_s1[c][SAMPLE_W-1], x_s1[c]})
			        - $signed({f_q[c][SAMPLE_W-1], f_q[c]});
			prod[c] = $signed({1'b0, g_eff}) * diff[c];
			rnd[c]  = prod[c] + $signed(BLEND_W'(BLEND_RND));
			f_upd[c] = seeded_q ? (f_q[c] + word_t'(rnd[c][GAIN_FRAC +: SAMPLE_W]))
			                    : x_s1[c];
		end
	end

	assign is_tare = (kind_s1 == KIND_TARE);
	assign cnt_inc = cnt_q + CNT_W'(1);
	assign done    = running_q && (cnt_inc == CNT_W'(TARE_SAMPLES));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seeded_q  <= 1'b0;
			running_q <= 1'b0;
			cnt_q     <= '0;
		end else if (adv && v_s1) begin
			if (is_tare) begin
				if (!running_q) begin
					running_q <= 1'b1;
					cnt_q     <= '0;
				end
			end else begin
				seeded_q <= !done;
				if (running_q) begin
					cnt_q <= done ? '0 : cnt_inc;
				end
				if (done) begin
					running_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv && v_s1 && !is_tare) begin
			f_q <= done ? '0 : f_upd;
		end
	end

	// stage 2 and later: control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2   <= 1'b0;
			clr_s2 <= 1'b0;
			v_s3   <= 1'b0;
			v_s4   <= 1'b0;
			v_s5   <= 1'b0;
			v_s6   <= 1'b0;
			dv_s3  <= 1'b0;
			dv_s4  <= 1'b0;
			dv_s5  <= 1'b0;
			dv_s6  <= 1'b0;
			off_q  <= '0;
		end else if (adv) begin
			v_s2   <= v_s1 && !is_tare;
			clr_s2 <= v_s1 && is_tare && !running_q;
			v_s3   <= v_s2;
			v_s4   <= v_s3;
			v_s5   <= v_s4;
			v_s6   <= v_s5;
			dv_s3  <= v_s2 && done_s2;
			dv_s4  <= dv_s3;
			dv_s5  <= dv_s4;
			dv_s6  <= dv_s5;
			if (dv_s6) begin
				for (int c = 0; c < CHANNELS; c++) begin
					off_q[c] <= avg[c];
				end
			end
		end
	end

	always_comb begin
		for (int c = 0; c < CHANNELS; c++) begin
			f_ext[c] = $signed({{(SUM_W-SAMPLE_W){f_s2[c][SAMPLE_W-1]}}, f_s2[c]});
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			acc_s2  <= running_q;
			done_s2 <= done;
			busy_s2 <= running_q && !done;
			f_s2    <= f_upd;
			busy_s3 <= busy_s2;
			busy_s4 <= busy_s3;
			busy_s5 <= busy_s4;
			busy_s6 <= busy_s5;
			f_s3    <= f_s2;
			f_s4    <= f_s3;
			f_s5    <= f_s4;
			f_s6    <= f_s5;
			for (int c = 0; c < CHANNELS; c++) begin
				fin_s3[c] <= sum_q[c] + f_ext[c];
				if (clr_s2) begin
					sum_q[c] <= '0;
				end else if (v_s2 && acc_s2) begin
					sum_q[c] <= done_s2 ? '0 : (sum_q[c] + f_ext[c]);
				end
			end
		end
	end

	for (genvar c = 0; c < CHANNELS; c++) begin : g_div
		wemaft_avg_div u_div (
			.clk (clk),
			.en  (adv),
			.sum (fin_s3[c]),
			.avg (avg[c])
		);
	end

	// offset removal with saturation
	always_comb begin
		for (int c = 0; c < CHANNELS; c++) begin
			tared[c] = $signed({f_s6[c][SAMPLE_W-1], f_s6[c]})
			         - $signed({off_q[c][SAMPLE_W-1], off_q[c]});
			if (tared[c][SAMPLE_W] != tared[c][SAMPLE_W-1]) begin
				rslt.val[c] = tared[c][SAMPLE_W] ? {1'b1, {(SAMPLE_W-1){1'b0}}}
				                                 : {1'b0, {(SAMPLE_W-1){1'b1}}};
			end else begin
				rslt.val[c] = tared[c][SAMPLE_W-1:0];
			end
		end
		rslt.busy = busy_s6;
	end

	wemaft_out_buf u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.up_valid (v_s6),
		.up_ready (adv),
		.up_data  (rslt),
		.dn_valid (out_valid),
		.dn_ready (out_ready),
		.dn_data  (out_data)
	);

	assign out_force_x  = $signed(out_data.val[0]);
	assign out_force_y  = $signed(out_data.val[1]);
	assign out_force_z  = $signed(out_data.val[2]);
	assign out_torque_x = $signed(out_data.val[3]);
	assign out_torque_y = $signed(out_data.val[4]);
	assign out_torque_z = $signed(out_data.val[5]);
	assign tare_busy    = out_data.busy;

	`WEMAFT_ASSERT_SAME(a_cnt_idle, !running_q, cnt_q == '0, "tare count not clear while idle")
	`WEMAFT_ASSERT_NEXT(a_tare_start, adv && v_s1 && is_tare && !running_q, running_q, "tare did not start")
	`WEMAFT_ASSERT_NEXT(a_tare_end, adv && v_s1 && !is_tare && done, !running_q && !seeded_q, "tare end did not reseed")
	`WEMAFT_ASSERT_SAME(a_div_align, dv_s6, v_s6, "offset update not aligned with its sample")

endmodule
